// File: rtl/pending_write_coalescing_buffer_core_macros.svh
// ---------------------------------------------------------------------------
// pending write coalescing buffer: assertion macros
// Check forms used by the core rtl file; expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef PENDING_WRITE_COALESCING_BUFFER_CORE_MACROS_SVH
`define PENDING_WRITE_COALESCING_BUFFER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PWCB_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pwcb check failed");

// next-cycle implication, checked outside reset
`define PWCB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pwcb check failed");

`endif

// File: rtl/pwcb_pkg.sv
// ---------------------------------------------------------------------------
// pwcb_pkg
// Types, codes and constants shared by the coalescing buffer modules.
// ---------------------------------------------------------------------------
`default_nettype none
package pwcb_pkg;

	// parameter defaults
	localparam int ADDR_W_DEF    = 32;
	localparam int BUDGET_DEF    = 1024;
	localparam int MAX_RUNS_DEF  = 64;
	localparam int PTR_BYTES_DEF = 8;

	// widest forms of the per-run fields
	localparam int ADDR_MAX_W  = 64;
	localparam int IDX_W       = 8;
	localparam int CTR_W       = 3;
	localparam int COST_W      = 10;
	localparam int RUN_MAX_LEN = 255;

	// commands
	localparam logic [2:0] CMD_WR      = 3'd0;
	localparam logic [2:0] CMD_HI      = 3'd1;
	localparam logic [2:0] CMD_LO      = 3'd2;
	localparam logic [2:0] CMD_RD      = 3'd3;
	localparam logic [2:0] CMD_DRAIN   = 3'd4;
	localparam logic [2:0] CMD_DISCARD = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] address;
		logic [7:0]  value;
		logic [7:0]  mem_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  data_byte;
		logic        changed;
		logic [31:0] write_address;
		logic        pending;
		logic        drained_last;
	} rsp_t;

	// one run as held in a cell
	typedef struct packed {
		logic [ADDR_MAX_W-1:0] start;
		logic [7:0]            len;
		logic [CTR_W-1:0]      ctr;
		logic [COST_W-1:0]     cost;
		logic [IDX_W-1:0]      page;
	} run_t;

	// lookup token walking down the cell row
	typedef struct packed {
		logic                  valid;
		logic [ADDR_MAX_W-1:0] addr;
		logic                  hit;
		logic [IDX_W-1:0]      hit_page;
		logic [7:0]            hit_off;
		logic                  ext;
		logic [IDX_W-1:0]      ext_idx;
		logic [IDX_W-1:0]      ext_page;
		logic [7:0]            ext_len;
		logic                  ext_ctr0;
	} tok_t;

	// update commands broadcast to the cells
	typedef struct packed {
		logic             shift;
		logic             ext;
		logic             open;
		logic [IDX_W-1:0] idx;
		run_t             run;
	} ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_OV_RD,
		S_WRITE,
		S_DRAIN_RD,
		S_DONE
	} fsm_t;

endpackage
`default_nettype wire

// File: rtl/pwcb_ram.sv
// ---------------------------------------------------------------------------
// pwcb_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module pwcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/pwcb_cell.sv
// ---------------------------------------------------------------------------
// pwcb_cell
// One run slot of the row: holds a run, checks the passing lookup token
// against it and hands the token to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none
module pwcb_cell #(
	parameter int IDX       = 0,
	parameter int ADDR_W    = 32,
	parameter int PTR_BYTES = 8,
	parameter int CNT_W     = 7
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [CNT_W-1:0]   run_count,
	input  wire logic [7:0]         cursor,
	input  wire pwcb_pkg::tok_t     tok_in,
	output pwcb_pkg::tok_t          tok_out,
	input  wire pwcb_pkg::run_t     nxt,
	output pwcb_pkg::run_t          cur,
	input  wire pwcb_pkg::ctl_t     ctl
);
	import pwcb_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	run_t              run_q;
	tok_t              tok_d;
	logic              tok_v_q;
	tok_t              tok_q;
	logic              live;
	logic [7:0]        lo;
	logic [ADDR_W-1:0] off;
	logic              hit;
	logic              ext;

	assign cur  = run_q;
	assign live = CNT_W'(IDX) < run_count;
	// bytes already drained from the head run are no longer pending
	assign lo   = (IDX == 0) ? cursor : 8'd0;
	assign off  = ADDR_W'(tok_in.addr) - ADDR_W'(run_q.start);
	assign hit  = live && (off >= ADDR_W'(lo)) && (off < ADDR_W'(run_q.len));
	assign ext  = live && (run_q.len != 8'(RUN_MAX_LEN)) &&
		((ADDR_W'(run_q.start) + ADDR_W'(run_q.len)) == ADDR_W'(tok_in.addr));

	// run storage: shift on head removal, grow on extend, load on open
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			run_q <= nxt;
		end else if (ctl.ext && ctl.idx == MY_IDX) begin
			run_q.len  <= run_q.len + 8'd1;
			run_q.ctr  <= (run_q.ctr == CTR_W'(PTR_BYTES - 1)) ? '0 : run_q.ctr + CTR_W'(1);
			run_q.cost <= run_q.cost + ((run_q.ctr == '0) ? COST_W'(PTR_BYTES) : '0);
		end else if (ctl.open && ctl.idx == MY_IDX) begin
			run_q <= ctl.run;
		end
	end

	// token update, earliest cell wins
	always_comb begin
		tok_d = tok_in;
		if (!tok_in.hit && hit) begin
			tok_d.hit      = 1'b1;
			tok_d.hit_page = run_q.page;
			tok_d.hit_off  = off[7:0];
		end
		if (!tok_in.ext && ext) begin
			tok_d.ext      = 1'b1;
			tok_d.ext_idx  = MY_IDX;
			tok_d.ext_page = run_q.page;
			tok_d.ext_len  = run_q.len;
			tok_d.ext_ctr0 = (run_q.ctr == '0);
		end
	end

	// token stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_v_q <= 1'b0;
		end else begin
			tok_v_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_v_q;
	end
endmodule
`default_nettype wire

// File: rtl/pending_write_coalescing_buffer_core.sv
// ---------------------------------------------------------------------------
// pending_write_coalescing_buffer_core
// Pending byte-write buffer: runs held in a row of cells, data in one RAM.
// ---------------------------------------------------------------------------
// One command word in, one result word out. Each write, nibble write or
// overlay read sends a lookup token down the row of MAX_RUNS run cells, one
// cell per cycle; a drain does one run data RAM read, a discard or an empty
// drain none. One word is worked on at a time; a new word is taken while
// the previous result still waits on the output register.
`default_nettype none
`include "pending_write_coalescing_buffer_core_macros.svh"
module pending_write_coalescing_buffer_core #(
	parameter int ADDR_W    = pwcb_pkg::ADDR_W_DEF,
	parameter int BUDGET    = pwcb_pkg::BUDGET_DEF,
	parameter int MAX_RUNS  = pwcb_pkg::MAX_RUNS_DEF,
	parameter int PTR_BYTES = pwcb_pkg::PTR_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire pwcb_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output pwcb_pkg::rsp_t      rsp
);
	import pwcb_pkg::*;

	localparam int PG_W  = $clog2(MAX_RUNS);
	localparam int CNT_W = $clog2(MAX_RUNS + 1);
	localparam int RA_W  = PG_W + 8;
	localparam int BUD_W = $clog2(BUDGET + 1) + 1;
	localparam logic [BUD_W-1:0] OPEN_COST = BUD_W'(2 * PTR_BYTES + 1);

	fsm_t state_q, state_d;

	logic [2:0]        cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        val_q;
	logic [7:0]        mem_q;
	logic [7:0]        nv_q;
	tok_t              tok_q;
	rsp_t              res_q;
	rsp_t              out_q;
	logic              out_v_q;

	logic [CNT_W-1:0] count_q;
	logic [BUD_W-1:0] budget_q;
	logic [7:0]       cursor_q;
	logic [PG_W-1:0]  head_q;

	tok_t tok [MAX_RUNS+1];
	run_t runs [MAX_RUNS+1];
	ctl_t ctl;

	logic            re, we;
	logic [RA_W-1:0] raddr, waddr;
	logic [7:0]      wdata, rdata;

	logic [ADDR_W-1:0] req_addr;
	logic [BUD_W-1:0]  add_ext;
	logic              ext_ok, open_ok;
	logic [PG_W:0]     pg_sum;
	logic [PG_W-1:0]   new_pg;
	logic              drain_end;
	logic [7:0]        ov_byte;
	logic [7:0]        nv;
	logic              take_out;

	assign req_addr  = ADDR_W'(req.address);
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;
	assign take_out  = !out_v_q || !rsp_stall;

	// row of run cells
	assign runs[MAX_RUNS] = '0;
	for (genvar i = 0; i < MAX_RUNS; i++) begin : g_cell
		pwcb_cell #(
			.IDX       (i),
			.ADDR_W    (ADDR_W),
			.PTR_BYTES (PTR_BYTES),
			.CNT_W     (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.run_count (count_q),
			.cursor    (cursor_q),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1]),
			.nxt       (runs[i+1]),
			.cur       (runs[i]),
			.ctl       (ctl)
		);
	end

	// run data, 256 byte page per run
	pwcb_ram #(
		.WIDTH (8),
		.DEPTH (MAX_RUNS * 256)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// budget and page checks for the write step
	assign add_ext = tok_q.ext_ctr0 ? BUD_W'(PTR_BYTES) : '0;
	assign ext_ok  = (budget_q + add_ext) <= BUD_W'(BUDGET);
	assign open_ok = (count_q < CNT_W'(MAX_RUNS)) &&
		((budget_q + OPEN_COST) <= BUD_W'(BUDGET));
	assign pg_sum  = (PG_W+1)'(head_q) + (PG_W+1)'(count_q);
	assign new_pg  = (pg_sum >= (PG_W+1)'(MAX_RUNS)) ?
		PG_W'(pg_sum - (PG_W+1)'(MAX_RUNS)) : pg_sum[PG_W-1:0];
	assign drain_end = ({1'b0, cursor_q} + 9'd1) >= {1'b0, runs[0].len};

	// nibble merge over the overlaid byte
	assign ov_byte = (state_q == S_OV_RD) ? rdata : mem_q;
	always_comb begin
		case (cmd_q)
			CMD_HI:  nv = {val_q[3:0], ov_byte[3:0]};
			CMD_LO:  nv = {ov_byte[7:4], val_q[3:0]};
			default: nv = val_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req.cmd) inside
						CMD_WR, CMD_HI, CMD_LO, CMD_RD: state_d = S_SCAN;
						CMD_DRAIN: state_d = (count_q != '0) ? S_DRAIN_RD : S_DONE;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (tok[MAX_RUNS].valid) begin
					if (cmd_q == CMD_RD) begin
						state_d = tok[MAX_RUNS].hit ? S_OV_RD : S_DONE;
					end else if (cmd_q != CMD_WR && tok[MAX_RUNS].hit) begin
						state_d = S_OV_RD;
					end else begin
						state_d = S_WRITE;
					end
				end
			end
			S_OV_RD:    state_d = (cmd_q == CMD_RD) ? S_DONE : S_WRITE;
			S_WRITE:    state_d = S_DONE;
			S_DRAIN_RD: state_d = S_DONE;
			S_DONE:     state_d = take_out ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	// control outputs: token launch, ram ports, cell updates
	always_comb begin
		req_stall = (state_q != S_IDLE);
		tok[0]    = '0;
		tok[0].addr = ADDR_MAX_W'(req_addr);
		re    = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = nv_q;
		ctl   = '0;
		unique case (state_q)
			S_IDLE: begin
				tok[0].valid = req_valid && (req.cmd <= CMD_RD);
				re    = req_valid && (req.cmd == CMD_DRAIN) && (count_q != '0);
				raddr = {runs[0].page[PG_W-1:0], cursor_q};
			end
			S_SCAN: begin
				re    = tok[MAX_RUNS].valid && tok[MAX_RUNS].hit && (cmd_q != CMD_WR);
				raddr = {tok[MAX_RUNS].hit_page[PG_W-1:0], tok[MAX_RUNS].hit_off};
			end
			S_WRITE: begin
				if (tok_q.hit) begin
					we    = 1'b1;
					waddr = {tok_q.hit_page[PG_W-1:0], tok_q.hit_off};
				end else if (tok_q.ext) begin
					we      = ext_ok;
					waddr   = {tok_q.ext_page[PG_W-1:0], tok_q.ext_len};
					ctl.ext = ext_ok;
					ctl.idx = tok_q.ext_idx;
				end else begin
					we       = open_ok;
					waddr    = {new_pg, 8'd0};
					ctl.open = open_ok;
					ctl.idx  = IDX_W'(count_q);
					ctl.run.start = ADDR_MAX_W'(addr_q);
					ctl.run.len   = 8'd1;
					ctl.run.ctr   = CTR_W'(1);
					ctl.run.cost  = COST_W'(OPEN_COST);
					ctl.run.page  = IDX_W'(new_pg);
				end
			end
			S_DRAIN_RD: begin
				ctl.shift = drain_end;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			budget_q <= '0;
			cursor_q <= '0;
			head_q   <= '0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && req_valid && req.cmd == CMD_DISCARD) begin
				count_q  <= '0;
				budget_q <= '0;
				cursor_q <= '0;
			end
			if (state_q == S_WRITE && !tok_q.hit) begin
				if (tok_q.ext) begin
					if (ext_ok) begin
						budget_q <= budget_q + add_ext;
					end
				end else if (open_ok) begin
					budget_q <= budget_q + OPEN_COST;
					count_q  <= count_q + CNT_W'(1);
				end
			end
			if (state_q == S_DRAIN_RD) begin
				if (drain_end) begin
					budget_q <= budget_q - BUD_W'(runs[0].cost);
					count_q  <= count_q - CNT_W'(1);
					cursor_q <= '0;
					head_q   <= (head_q == PG_W'(MAX_RUNS - 1)) ? '0 : head_q + PG_W'(1);
				end else begin
					cursor_q <= cursor_q + 8'd1;
				end
			end
			if (state_q == S_DONE && take_out) begin
				out_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// command word and result assembly
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q  <= req.cmd;
				addr_q <= req_addr;
				val_q  <= req.value;
				mem_q  <= req.mem_byte;
				res_q  <= '0;
				if (req.cmd == CMD_DRAIN && count_q == '0) begin
					res_q.status <= ST_EMPTY;
				end
			end
			S_SCAN: begin
				tok_q <= tok[MAX_RUNS];
				nv_q  <= nv;
				if (cmd_q == CMD_RD) begin
					res_q.data_byte <= mem_q;
				end
			end
			S_OV_RD: begin
				nv_q <= nv;
				if (cmd_q == CMD_RD) begin
					res_q.data_byte <= rdata;
					res_q.changed   <= 1'b1;
				end
			end
			S_WRITE: begin
				if (!tok_q.hit && ((tok_q.ext && !ext_ok) || (!tok_q.ext && !open_ok))) begin
					res_q.status <= ST_FULL;
				end
			end
			S_DRAIN_RD: begin
				res_q.data_byte     <= rdata;
				res_q.write_address <= 32'(ADDR_W'(runs[0].start) + ADDR_W'(cursor_q));
				res_q.drained_last  <= drain_end && (count_q == CNT_W'(1));
			end
			S_DONE: begin
				if (take_out) begin
					out_q         <= res_q;
					out_q.pending <= (count_q != '0);
				end
			end
			default: begin
			end
		endcase
	end

	`PWCB_ASSERT_IMPL(a_count_max, 1'b1, count_q <= CNT_W'(MAX_RUNS))
	`PWCB_ASSERT_IMPL(a_budget_max, 1'b1, budget_q <= BUD_W'(BUDGET))
	`PWCB_ASSERT_IMPL(a_tok_in_scan, tok[MAX_RUNS].valid, state_q == S_SCAN)
	`PWCB_ASSERT_IMPL(a_cursor_in_run, count_q != '0, cursor_q < runs[0].len)
	`PWCB_ASSERT_NEXT(a_empty_clean, count_q == '0 && state_q != S_WRITE, cursor_q == '0)
endmodule
`default_nettype wire

// File: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives command words into the coalescing buffer and checks every result
// word against a behavioral copy of the run list kept in the bench.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
	import pwcb_pkg::*;

	localparam int BUDGET_B  = 1024;
	localparam int RUNS_MAX  = 64;
	localparam int PTR_B     = 8;
	localparam int RANDOM_N  = 80;
	localparam int HOLD_N    = 600;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	pending_write_coalescing_buffer_core u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// shadow copy of the pending runs
	logic [31:0] sh_start [RUNS_MAX];
	int          sh_len [RUNS_MAX];
	logic [7:0]  sh_data [RUNS_MAX][256];
	int          sh_count;
	int          sh_budget;
	int          sh_cursor;

	req_t cmd_queue [$];
	rsp_t expected_rsp [$];
	int   mismatches;
	bit   stimulus_done;
	logic hold_on;

	function automatic int run_cost(int len);
		return PTR_B + 1 + ((len + PTR_B - 1) / PTR_B) * PTR_B;
	endfunction

	// run index covering addr (undrained part only), or -1
	function automatic int find_run(logic [31:0] addr, output int off);
		logic [31:0] o;
		off = 0;
		for (int r = 0; r < sh_count; r++) begin
			o = addr - sh_start[r];
			if (o >= ((r == 0) ? sh_cursor : 0) && o < sh_len[r]) begin
				off = o;
				return r;
			end
		end
		return -1;
	endfunction

	function automatic logic [1:0] store_byte(logic [31:0] addr, logic [7:0] v);
		int off;
		int h;
		int add;
		h = find_run(addr, off);
		if (h >= 0) begin
			sh_data[h][off] = v;
			return ST_OK;
		end
		for (int r = 0; r < sh_count; r++) begin
			if (sh_len[r] < 255 && sh_start[r] + 32'(sh_len[r]) == addr) begin
				add = (sh_len[r] % PTR_B == 0) ? PTR_B : 0;
				if (sh_budget + add > BUDGET_B)
					return ST_FULL;
				sh_budget += add;
				sh_data[r][sh_len[r]] = v;
				sh_len[r]++;
				return ST_OK;
			end
		end
		if (sh_count >= RUNS_MAX || sh_budget + run_cost(1) > BUDGET_B)
			return ST_FULL;
		sh_budget += run_cost(1);
		sh_start[sh_count] = addr;
		sh_len[sh_count] = 1;
		sh_data[sh_count][0] = v;
		sh_count++;
		return ST_OK;
	endfunction

	// advance the shadow state by one command word, return its result
	function automatic rsp_t buffer_step(req_t w);
		rsp_t o;
		int off;
		int h;
		logic [7:0] cur;
		logic [7:0] nv;
		o = '0;
		case (w.cmd)
			CMD_WR, CMD_HI, CMD_LO: begin
				nv = w.value;
				if (w.cmd != CMD_WR) begin
					h = find_run(w.address, off);
					cur = (h >= 0) ? sh_data[h][off] : w.mem_byte;
					if (w.cmd == CMD_HI)
						nv = {w.value[3:0], cur[3:0]};
					else
						nv = {cur[7:4], w.value[3:0]};
				end
				o.status = store_byte(w.address, nv);
			end
			CMD_RD: begin
				h = find_run(w.address, off);
				o.data_byte = (h >= 0) ? sh_data[h][off] : w.mem_byte;
				o.changed = (h >= 0);
			end
			CMD_DRAIN: begin
				if (sh_count == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.data_byte = sh_data[0][sh_cursor];
					o.write_address = sh_start[0] + 32'(sh_cursor);
					sh_cursor++;
					if (sh_cursor >= sh_len[0]) begin
						sh_budget -= run_cost(sh_len[0]);
						for (int r = 0; r < sh_count - 1; r++) begin
							sh_start[r] = sh_start[r + 1];
							sh_len[r] = sh_len[r + 1];
							sh_data[r] = sh_data[r + 1];
						end
						sh_count--;
						sh_cursor = 0;
						o.drained_last = (sh_count == 0);
					end
				end
			end
			CMD_DISCARD: begin
				sh_count = 0;
				sh_budget = 0;
				sh_cursor = 0;
			end
			default: ;
		endcase
		o.pending = (sh_count != 0);
		return o;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	function automatic req_t mk_word(logic [2:0] c, logic [31:0] a, logic [7:0] v,
			logic [7:0] m);
		req_t w;
		w.cmd = c;
		w.address = a;
		w.value = v;
		w.mem_byte = m;
		return w;
	endfunction

	// driver: one word offered at a time, held until accepted
	int src_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			src_gap <= 0;
		end else if (req_valid && !req_stall) begin
			expected_rsp.push_back(buffer_step(req));
			if (src_gap == 0 && cmd_queue.size() > 0) begin
				req <= cmd_queue.pop_front();
				src_gap <= gap_len();
			end else begin
				req_valid <= 1'b0;
			end
		end else if (!req_valid) begin
			if (src_gap > 0)
				src_gap <= src_gap - 1;
			else if (cmd_queue.size() > 0) begin
				req <= cmd_queue.pop_front();
				req_valid <= 1'b1;
				src_gap <= gap_len();
			end
		end
	end

	// long receiver hold while the sender keeps offering
	initial begin
		hold_on = 1'b0;
		wait (stimulus_done && cmd_queue.size() < RANDOM_N / 2);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_N) @(posedge clk);
		hold_on <= 1'b0;
	end

	// monitor and receiver stall
	int sink_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %p", rsp);
				end else if (rsp !== expected_rsp[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", expected_rsp[0], rsp);
					void'(expected_rsp.pop_front());
				end else begin
					void'(expected_rsp.pop_front());
				end
			end
			if (hold_on) begin
				rsp_stall <= 1'b1;
			end else if (sink_gap > 0) begin
				rsp_stall <= 1'b1;
				sink_gap <= sink_gap - 1;
			end else begin
				rsp_stall <= 1'b0;
				sink_gap <= ($urandom_range(0, 1) == 0) ? 0 : gap_len();
			end
		end
	end

	// stimulus
	logic [31:0] base;
	int kind;
	initial begin
		mismatches = 0;
		stimulus_done = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty drain, field extremes, every command
		cmd_queue.push_back(mk_word(CMD_DRAIN, 0, 0, 0));
		cmd_queue.push_back(mk_word(CMD_RD, 32'hffffffff, 0, 8'hff));
		cmd_queue.push_back(mk_word(CMD_WR, 32'hffffffff, 8'hff, 0));
		cmd_queue.push_back(mk_word(CMD_WR, 32'h0, 8'h00, 8'hff));  // extend across wrap
		cmd_queue.push_back(mk_word(CMD_HI, 32'h0, 8'h5a, 8'h33));
		cmd_queue.push_back(mk_word(CMD_LO, 32'hffffffff, 8'ha5, 8'h00));
		cmd_queue.push_back(mk_word(CMD_HI, 32'h1234, 8'hf3, 8'hc9));  // nibble over memory
		cmd_queue.push_back(mk_word(CMD_LO, 32'h1235, 8'h0e, 8'h7b));
		cmd_queue.push_back(mk_word(CMD_RD, 32'h0, 0, 8'h11));
		cmd_queue.push_back(mk_word(CMD_RD, 32'h1236, 0, 8'h22));
		cmd_queue.push_back(mk_word(CMD_DRAIN, 0, 0, 0));
		cmd_queue.push_back(mk_word(CMD_RD, 32'hffffffff, 0, 8'h44));  // drained byte
		cmd_queue.push_back(mk_word(CMD_WR, 32'hffffffff, 8'h66, 0));
		cmd_queue.push_back(mk_word(3'd6, 32'h55, 8'h55, 8'h55));
		cmd_queue.push_back(mk_word(3'd7, 32'haa, 8'haa, 8'haa));
		cmd_queue.push_back(mk_word(CMD_DISCARD, 0, 0, 0));
		cmd_queue.push_back(mk_word(CMD_DRAIN, 0, 0, 0));
		// saturate one run to 255 and step past it
		for (int i = 0; i < 256; i++)
			cmd_queue.push_back(mk_word(CMD_WR, 32'h8000 + i, i[7:0], 0));
		cmd_queue.push_back(mk_word(CMD_RD, 32'h80ff, 0, 8'h99));
		// fill budget with single-byte runs until refused
		for (int i = 0; i < 48; i++)
			cmd_queue.push_back(mk_word(CMD_WR, 32'h100000 + 32'(i) * 16, 8'h3c, 0));
		for (int i = 0; i < 300; i++)
			cmd_queue.push_back(mk_word(CMD_DRAIN, 0, 0, 0));

		// random: bursts of writes near a few bases, reads, drains, rare discards
		base = $urandom();
		for (int i = 0; i < RANDOM_N; i++) begin
			if ($urandom_range(0, 40) == 0)
				base = $urandom();
			kind = $urandom_range(0, 99);
			if (kind < 45)
				cmd_queue.push_back(mk_word(3'($urandom_range(0, 2)),
					base + $urandom_range(0, 40), 8'($urandom()), 8'($urandom())));
			else if (kind < 65)
				cmd_queue.push_back(mk_word(CMD_RD, base + $urandom_range(0, 40),
					8'($urandom()), 8'($urandom())));
			else if (kind < 88)
				cmd_queue.push_back(mk_word(CMD_DRAIN, $urandom(), 8'($urandom()),
					8'($urandom())));
			else if (kind < 90)
				cmd_queue.push_back(mk_word(CMD_DISCARD, $urandom(), 8'($urandom()),
					8'($urandom())));
			else if (kind < 92)
				cmd_queue.push_back(mk_word(3'($urandom_range(6, 7)), $urandom(),
					8'($urandom()), 8'($urandom())));
			else
				cmd_queue.push_back(mk_word(3'($urandom_range(0, 3)), $urandom(),
					8'($urandom()), 8'($urandom())));
		end
		stimulus_done = 1;

		wait (cmd_queue.size() == 0 && !req_valid && expected_rsp.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#100000000;
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/pwcb_pkg.sv
rtl/pwcb_ram.sv
rtl/pwcb_cell.sv
rtl/pending_write_coalescing_buffer_core.sv
sim/tb_top.sv
